>>> hdl/pswbd_pkg.sv
// Shared types and constants of the per-source burst detector.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package pswbd_pkg;

	localparam int SID_BITS       = 4;
	localparam int TS_BITS        = 48;
	localparam int SEV_BITS       = 2;
	localparam int WINDOW_BITS    = 32;
	localparam int COUNT_BITS     = 7;
	localparam int SRC_BITS       = 8;
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [SEV_BITS-1:0] SEV_DEBUG = 2'd0;
	localparam logic [SEV_BITS-1:0] SEV_ERROR = 2'd2;

	localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW    = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DROP      = 2'd2;

	localparam logic [COUNT_BITS-1:0] COUNT_SAT = 7'd127;

	typedef struct packed {
		logic [WINDOW_BITS-1:0] window_ms;
		logic [COUNT_BITS-1:0]  burst_threshold;
		logic                   discard_debug;
	} cfg_t;

	typedef struct packed {
		logic [SID_BITS-1:0] sid;
		logic [TS_BITS-1:0]  ts;
		logic [SEV_BITS-1:0] sev;
		logic                err;
		logic [SRC_BITS-1:0] src;
	} item_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_META,
		BK_READ,
		BK_CHECK,
		BK_DONE,
		BK_EMIT
	} back_state_t;

endpackage
`default_nettype wire

>>> hdl/pswbd_front.sv
// Front end: accepts events, drops debug events when enabled, classifies
// severity and reduces the source number to a ring index. Depends on pswbd_pkg.
`default_nettype none
module pswbd_front import pswbd_pkg::*; #(
	parameter int SOURCES = 16
) (
	input  wire cfg_t                cfg,
	input  wire logic                event_valid,
	output logic                     event_ready,
	input  wire logic [SID_BITS-1:0] source_id,
	input  wire logic [TS_BITS-1:0]  timestamp_ms,
	input  wire logic [SEV_BITS-1:0] severity_class,
	output logic                     push_valid,
	input  wire logic                push_ready,
	output item_t                    push_item
);

	logic                drop;
	logic [SRC_BITS-1:0] src;

	always_comb begin
		src = '0;
		for (int i = 0; i < (1 << SID_BITS); i++) begin
			if (source_id == SID_BITS'(i)) begin
				src = SRC_BITS'(i % SOURCES);
			end
		end
	end

	assign drop        = cfg.discard_debug && (severity_class == SEV_DEBUG);
	assign event_ready = push_ready;
	assign push_valid  = event_valid && !drop;

	always_comb begin
		push_item.sid = source_id;
		push_item.ts  = timestamp_ms;
		push_item.sev = severity_class;
		push_item.err = severity_class >= SEV_ERROR;
		push_item.src = src;
	end

endmodule
`default_nettype wire

>>> hdl/pswbd_fifo.sv
// Two-entry queue of classified events between front and back end.
// Depends on pswbd_pkg for the item type.
`default_nettype none
module pswbd_fifo import pswbd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push_valid,
	output logic       push_ready,
	input  wire item_t push_item,
	output logic       pop_valid,
	input  wire logic  pop_ready,
	output item_t      pop_item
);

	item_t      slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = count_q != 2'd2;
	assign pop_valid  = count_q != 2'd0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

>>> hdl/pswbd_back.sv
// Back end: per-source timestamp rings, window retirement, burst decision
// and the output register. Depends on pswbd_pkg.
`default_nettype none
module pswbd_back import pswbd_pkg::*; #(
	parameter int SOURCES       = 16,
	parameter int HISTORY_DEPTH = 64,
	parameter int TIME_BITS     = 48
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cfg_t                cfg,
	input  wire logic                pop_valid,
	output logic                     pop_ready,
	input  wire item_t               pop_item,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output logic [SID_BITS-1:0]      out_source_id,
	output logic [TS_BITS-1:0]       out_timestamp_ms,
	output logic [SEV_BITS-1:0]      out_severity_class,
	output logic                     burst,
	output logic [COUNT_BITS-1:0]    window_count
);

	localparam int SW      = (SOURCES > 1) ? $clog2(SOURCES) : 1;
	localparam int DW      = $clog2(HISTORY_DEPTH);
	localparam int CW      = $clog2(HISTORY_DEPTH + 1);
	localparam int ENTRIES = SOURCES * HISTORY_DEPTH;
	localparam int AW      = $clog2(ENTRIES);
	localparam int TB      = (TIME_BITS < TS_BITS) ? TIME_BITS : TS_BITS;
	localparam int DIFF_W  = (TB > WINDOW_BITS) ? TB : WINDOW_BITS;
	localparam int CMP_W   = (CW > COUNT_BITS) ? CW : COUNT_BITS;
	localparam logic [DW-1:0] HEAD_LAST  = DW'(HISTORY_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_FULL = CW'(HISTORY_DEPTH);
	localparam logic [DW:0]   DEPTH_WRAP = (DW + 1)'(HISTORY_DEPTH);

	back_state_t state_q, state_d;

	item_t               item_q;
	logic [AW-1:0]       base_q;
	logic [DW-1:0]       head_q;
	logic [CW-1:0]       cnt_q;
	logic                burst_q;
	logic [COUNT_BITS-1:0] bcount_q;

	logic [DW+CW-1:0]    meta_mem [SOURCES];
	logic [SOURCES-1:0]  meta_vld_q;
	logic [DW+CW-1:0]    meta_rd_q;
	logic                meta_hit_q;
	logic [TB-1:0]       ring_mem [ENTRIES];
	logic [TB-1:0]       ring_rd_q;

	logic                out_valid_q;
	logic [SID_BITS-1:0] out_sid_q;
	logic [TS_BITS-1:0]  out_ts_q;
	logic [SEV_BITS-1:0] out_sev_q;
	logic                out_burst_q;
	logic [COUNT_BITS-1:0] out_count_q;

	logic [SW-1:0]       meta_raddr;
	logic [SW-1:0]       item_src;
	logic [DW-1:0]       head_in;
	logic [CW-1:0]       cnt_in;
	logic [DW:0]         slot_sum;
	logic [DW-1:0]       wr_slot;
	logic [DW-1:0]       head_in_inc;
	logic [DW-1:0]       head_inc;
	logic                ring_full;
	logic                ring_we;
	logic [AW-1:0]       ring_waddr;
	logic [AW-1:0]       ring_raddr;
	logic [TB-1:0]       now;
	logic [TB-1:0]       age;
	logic                retire;
	logic                pop;
	logic                load_out;
	logic                meta_we;
	logic                burst_hit;

	assign meta_raddr = pop_item.src[SW-1:0];
	assign item_src   = item_q.src[SW-1:0];
	assign now        = item_q.ts[TB-1:0];

	assign head_in     = meta_hit_q ? meta_rd_q[DW+CW-1:CW] : '0;
	assign cnt_in      = meta_hit_q ? meta_rd_q[CW-1:0] : '0;
	assign ring_full   = cnt_in == DEPTH_FULL;
	assign slot_sum    = (DW + 1)'(head_in) + (DW + 1)'(cnt_in);
	assign head_in_inc = (head_in == HEAD_LAST) ? '0 : head_in + DW'(1);
	assign head_inc    = (head_q == HEAD_LAST) ? '0 : head_q + DW'(1);

	always_comb begin
		if (ring_full) begin
			wr_slot = head_in;
		end else if (slot_sum >= DEPTH_WRAP) begin
			wr_slot = DW'(slot_sum - DEPTH_WRAP);
		end else begin
			wr_slot = slot_sum[DW-1:0];
		end
	end

	assign ring_waddr = base_q + AW'(wr_slot);
	assign ring_raddr = base_q + AW'(head_q);
	assign age        = now - ring_rd_q;
	assign retire     = (now >= ring_rd_q) && (DIFF_W'(age) > DIFF_W'(cfg.window_ms));
	assign burst_hit  = CMP_W'(cnt_q) >= CMP_W'(cfg.burst_threshold);

	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		ring_we   = 1'b0;
		meta_we   = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					state_d = pop_item.err ? BK_META : BK_EMIT;
				end
			end
			BK_META: begin
				ring_we = 1'b1;
				state_d = BK_READ;
			end
			BK_READ: begin
				state_d = BK_CHECK;
			end
			BK_CHECK: begin
				if (retire && cnt_q != CW'(1)) begin
					state_d = BK_READ;
				end else begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				meta_we = 1'b1;
				state_d = BK_EMIT;
			end
			BK_EMIT: begin
				if (!out_valid_q || result_ready) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			meta_vld_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (meta_we) begin
				meta_vld_q[item_src] <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				if (pop) begin
					item_q   <= pop_item;
					base_q   <= AW'(meta_raddr) * AW'(HISTORY_DEPTH);
					burst_q  <= 1'b0;
					bcount_q <= '0;
				end
			end
			BK_META: begin
				if (ring_full) begin
					head_q <= head_in_inc;
					cnt_q  <= cnt_in;
				end else begin
					head_q <= head_in;
					cnt_q  <= cnt_in + CW'(1);
				end
			end
			BK_CHECK: begin
				if (retire) begin
					head_q <= head_inc;
					cnt_q  <= cnt_q - CW'(1);
				end
			end
			BK_DONE: begin
				burst_q  <= burst_hit;
				bcount_q <= !burst_hit ? '0
					: (CMP_W'(cnt_q) > CMP_W'(COUNT_SAT)) ? COUNT_SAT : COUNT_BITS'(cnt_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		meta_rd_q  <= meta_mem[meta_raddr];
		meta_hit_q <= meta_vld_q[meta_raddr];
		if (meta_we) begin
			meta_mem[item_src] <= {head_q, cnt_q};
		end
	end

	always_ff @(posedge clk) begin
		ring_rd_q <= ring_mem[ring_raddr];
		if (ring_we) begin
			ring_mem[ring_waddr] <= now;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_sid_q   <= item_q.sid;
			out_ts_q    <= item_q.ts;
			out_sev_q   <= item_q.sev;
			out_burst_q <= burst_q;
			out_count_q <= bcount_q;
		end
	end

	assign result_valid       = out_valid_q;
	assign out_source_id      = out_sid_q;
	assign out_timestamp_ms   = out_ts_q;
	assign out_severity_class = out_sev_q;
	assign burst              = out_burst_q;
	assign window_count       = out_count_q;

endmodule
`default_nettype wire

>>> hdl/per_key_sliding_window_burst_detector_unit.sv
// Per-source sliding-window burst detector: front end, event queue, back end.
// A non-error event passes from the queue through the emit state into the output
// register; an error event first runs meta, read, check (read and check again per
// retired ring entry) and done. The next event is taken once the last is loaded.
// Reset clears control and per-source valid bits and sets the config registers to
// their defaults; ring timestamps are not cleared and no clearing pass runs.
`default_nettype none
module per_key_sliding_window_burst_detector_unit import pswbd_pkg::*; #(
	parameter int SOURCES       = 16,
	parameter int HISTORY_DEPTH = 64,
	parameter int TIME_BITS     = 48
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_write,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [WINDOW_BITS-1:0]    cfg_data,
	input  wire logic                      event_valid,
	output logic                           event_ready,
	input  wire logic [SID_BITS-1:0]       source_id,
	input  wire logic [TS_BITS-1:0]        timestamp_ms,
	input  wire logic [SEV_BITS-1:0]       severity_class,
	output logic                           result_valid,
	input  wire logic                      result_ready,
	output logic [SID_BITS-1:0]            out_source_id,
	output logic [TS_BITS-1:0]             out_timestamp_ms,
	output logic [SEV_BITS-1:0]            out_severity_class,
	output logic                           burst,
	output logic [COUNT_BITS-1:0]          window_count
);

	cfg_t  cfg_q;
	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	logic  pop_valid;
	logic  pop_ready;
	item_t pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_ms       <= WINDOW_BITS'(60000);
			cfg_q.burst_threshold <= COUNT_BITS'(5);
			cfg_q.discard_debug   <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_WINDOW:    cfg_q.window_ms       <= cfg_data;
				REG_THRESHOLD: cfg_q.burst_threshold <= cfg_data[COUNT_BITS-1:0];
				REG_DROP:      cfg_q.discard_debug   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	pswbd_front #(
		.SOURCES(SOURCES)
	) u_front (
		.cfg           (cfg_q),
		.event_valid   (event_valid),
		.event_ready   (event_ready),
		.source_id     (source_id),
		.timestamp_ms  (timestamp_ms),
		.severity_class(severity_class),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_item     (push_item)
	);

	pswbd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item)
	);

	pswbd_back #(
		.SOURCES      (SOURCES),
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.TIME_BITS    (TIME_BITS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.pop_valid         (pop_valid),
		.pop_ready         (pop_ready),
		.pop_item          (pop_item),
		.result_valid      (result_valid),
		.result_ready      (result_ready),
		.out_source_id     (out_source_id),
		.out_timestamp_ms  (out_timestamp_ms),
		.out_severity_class(out_severity_class),
		.burst             (burst),
		.window_count      (window_count)
	);

endmodule
`default_nettype wire

>>> bench/burst_checker.sv
// Checker for the per-source burst detector: tracks register writes, predicts each
// passed event from per-source timestamp rings and compares every result in order.
// Depends on pswbd_pkg for field widths, severity codes and register indexes.
`timescale 1ns / 1ps
module burst_checker import pswbd_pkg::*; #(
	parameter int SOURCES       = 16,
	parameter int HISTORY_DEPTH = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_write,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [WINDOW_BITS-1:0]    cfg_data,
	input  wire logic                      event_valid,
	input  wire logic                      event_ready,
	input  wire logic [SID_BITS-1:0]       source_id,
	input  wire logic [TS_BITS-1:0]        timestamp_ms,
	input  wire logic [SEV_BITS-1:0]       severity_class,
	input  wire logic                      result_valid,
	input  wire logic                      result_ready,
	input  wire logic [SID_BITS-1:0]       out_source_id,
	input  wire logic [TS_BITS-1:0]        out_timestamp_ms,
	input  wire logic [SEV_BITS-1:0]       out_severity_class,
	input  wire logic                      burst,
	input  wire logic [COUNT_BITS-1:0]     window_count,
	output int                             pending,
	output int                             failures
);

	localparam int AWAIT_DEPTH = 64;

	typedef struct packed {
		logic [SID_BITS-1:0]   sid;
		logic [TS_BITS-1:0]    ts;
		logic [SEV_BITS-1:0]   sev;
		logic                  burst;
		logic [COUNT_BITS-1:0] count;
	} passed_event_t;

	logic [TS_BITS-1:0]     ring_times [SOURCES][HISTORY_DEPTH];
	int                     ring_head [SOURCES];
	int                     ring_fill [SOURCES];
	logic [WINDOW_BITS-1:0] window_len;
	logic [COUNT_BITS-1:0]  threshold;
	logic                   discard_debug;
	passed_event_t          awaited [AWAIT_DEPTH];
	int                     sent_count;
	int                     seen_count;
	passed_event_t          predicted;
	int                     in_window;

	function automatic int record_error_count(input int src, input logic [TS_BITS-1:0] now);
		int head;
		int fill;
		logic [TS_BITS-1:0] oldest;
		head = ring_head[src];
		fill = ring_fill[src];
		if (fill < HISTORY_DEPTH) begin
			ring_times[src][(head + fill) % HISTORY_DEPTH] = now;
			fill++;
		end else begin
			ring_times[src][head] = now;
			head = (head + 1) % HISTORY_DEPTH;
		end
		// retire stale entries, oldest first; a later-than-now entry has age zero
		while (fill > 0) begin
			oldest = ring_times[src][head];
			if (now < oldest || (now - oldest) <= TS_BITS'(window_len))
				break;
			head = (head + 1) % HISTORY_DEPTH;
			fill--;
		end
		ring_head[src] = head;
		ring_fill[src] = fill;
		return fill;
	endfunction

	task automatic report_field(input string label, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			failures++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SOURCES; s++) begin
				ring_head[s] = 0;
				ring_fill[s] = 0;
			end
			window_len = 32'd60000;
			threshold = 7'd5;
			discard_debug = 1'b0;
			sent_count = 0;
			seen_count = 0;
			failures = 0;
			pending <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_WINDOW: window_len = cfg_data;
					REG_THRESHOLD: threshold = cfg_data[COUNT_BITS-1:0];
					REG_DROP: discard_debug = cfg_data[0];
					default: ;
				endcase
			end
			if (result_valid && result_ready) begin
				if (sent_count == seen_count) begin
					failures++;
					$display("%0t: unexpected result, expected none, got source %0h time %0h class %0h",
						$time, out_source_id, out_timestamp_ms, out_severity_class);
				end else begin
					predicted = awaited[seen_count % AWAIT_DEPTH];
					seen_count++;
					report_field("out_source_id", 64'(predicted.sid), 64'(out_source_id));
					report_field("out_timestamp_ms", 64'(predicted.ts), 64'(out_timestamp_ms));
					report_field("out_severity_class", 64'(predicted.sev),
						64'(out_severity_class));
					report_field("burst", 64'(predicted.burst), 64'(burst));
					report_field("window_count", 64'(predicted.count), 64'(window_count));
				end
			end
			if (event_valid && event_ready && !(discard_debug && severity_class == SEV_DEBUG)) begin
				predicted.sid = source_id;
				predicted.ts = timestamp_ms;
				predicted.sev = severity_class;
				predicted.burst = 1'b0;
				predicted.count = '0;
				if (severity_class >= SEV_ERROR) begin
					in_window = record_error_count(int'(source_id) % SOURCES, timestamp_ms);
					if (in_window >= int'(threshold)) begin
						predicted.burst = 1'b1;
						predicted.count = (in_window > int'(COUNT_SAT)) ? COUNT_SAT
							: COUNT_BITS'(in_window);
					end
				end
				awaited[sent_count % AWAIT_DEPTH] = predicted;
				sent_count++;
			end
			pending <= sent_count - seen_count;
		end
	end

endmodule

>>> bench/testbench.sv
// Top of the burst detector bench: clock, reset, register settings and event requests
// with random idling on both channels; burst_checker does prediction and comparison.
// Depends on pswbd_pkg, the detector unit and bench/burst_checker.sv.
`timescale 1ns / 1ps
module testbench;
	import pswbd_pkg::*;

	localparam int SOURCES       = 16;
	localparam int HISTORY_DEPTH = 64;
	localparam int TIME_BITS     = 48;
	localparam int SETTLE_CYCLES = 200;
	localparam int HOLD_CYCLES   = 600;

	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;
	localparam logic [SEV_BITS-1:0] SEV_INFO  = 2'd1;
	localparam logic [SEV_BITS-1:0] SEV_FATAL = 2'd3;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_write = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = REG_WINDOW;
	logic [WINDOW_BITS-1:0]    cfg_data = '0;
	logic                      event_valid = 1'b0;
	logic                      event_ready;
	logic [SID_BITS-1:0]       source_id = '0;
	logic [TS_BITS-1:0]        timestamp_ms = '0;
	logic [SEV_BITS-1:0]       severity_class = SEV_DEBUG;
	logic                      result_valid;
	logic                      result_ready = 1'b0;
	logic [SID_BITS-1:0]       out_source_id;
	logic [TS_BITS-1:0]        out_timestamp_ms;
	logic [SEV_BITS-1:0]       out_severity_class;
	logic                      burst;
	logic [COUNT_BITS-1:0]     window_count;
	int                        pending;
	int                        failures;

	bit                        quiet = 1'b0;
	int                        hold_asks = 0;
	logic [TS_BITS-1:0]        clock_now = '0;

	per_key_sliding_window_burst_detector_unit #(
		.SOURCES(SOURCES),
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.TIME_BITS(TIME_BITS)
	) dut (.*);

	burst_checker #(
		.SOURCES(SOURCES),
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) burst_watch (.*);

	always #4 clk = ~clk;

	task automatic offer_event(input logic [SID_BITS-1:0] sid, input logic [TS_BITS-1:0] ts,
			input logic [SEV_BITS-1:0] sev);
		event_valid <= 1'b1;
		source_id <= sid;
		timestamp_ms <= ts;
		severity_class <= sev;
		do @(posedge clk); while (!event_ready);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			event_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		event_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [WINDOW_BITS-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_random_events(input int count, input int source_span, input int step_max,
			input int error_pct);
		logic [63:0]         wide;
		logic [TS_BITS-1:0]  ts;
		logic [SEV_BITS-1:0] sev;
		int                  pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 31);
			if (pick == 0) begin
				wide = {$urandom, $urandom};
				ts = wide[TS_BITS-1:0];
			end else if (pick < 4) begin
				ts = clock_now - TS_BITS'($urandom_range(0, step_max));
			end else begin
				clock_now = clock_now + TS_BITS'($urandom_range(0, step_max));
				ts = clock_now;
			end
			if ($urandom_range(0, 99) < error_pct)
				sev = $urandom_range(0, 1) ? SEV_FATAL : SEV_ERROR;
			else
				sev = $urandom_range(0, 1) ? SEV_INFO : SEV_DEBUG;
			offer_event(SID_BITS'($urandom_range(0, source_span - 1)), ts, sev);
		end
	endtask

	initial begin
		int hold_done;
		hold_done = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_asks != hold_done) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done++;
				result_ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				result_ready <= 1'b1;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [63:0] wide;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: build a burst on one source, then let it age out
		for (int i = 1; i <= 6; i++)
			offer_event(4'd0, TS_BITS'(i * 1000), SEV_ERROR);
		offer_event(4'd0, 48'd7000, SEV_FATAL);
		offer_event(4'd0, 48'd7000, SEV_INFO);
		offer_event(4'd0, 48'd7000, SEV_DEBUG);
		offer_event(4'd0, 48'd100000, SEV_ERROR);
		offer_event(4'd1, 48'd500000, SEV_ERROR);
		offer_event(4'd1, 48'd400000, SEV_ERROR);
		offer_event(4'd15, 48'hFFFF_FFFF_FFFF, SEV_FATAL);
		offer_event(4'd15, 48'h0, SEV_ERROR);
		drain_results();

		// zero window, zero threshold, debug drop; spare index must be ignored
		write_register(REG_WINDOW, 32'd0);
		write_register(REG_THRESHOLD, 32'hFFFF_FF80);
		write_register(REG_DROP, 32'hFFFF_FFFF);
		write_register(REG_SPARE, 32'hFFFF_FFFF);
		offer_event(4'd3, 48'd10, SEV_DEBUG);
		offer_event(4'd3, 48'd10, SEV_ERROR);
		offer_event(4'd3, 48'd10, SEV_ERROR);
		offer_event(4'd3, 48'd11, SEV_ERROR);
		offer_event(4'd3, 48'd11, SEV_INFO);
		offer_event(4'd3, 48'd12, SEV_DEBUG);
		drain_results();

		clock_now = 48'd1_000_000;
		write_register(REG_WINDOW, 32'd60000);
		write_register(REG_THRESHOLD, 32'd5);
		write_register(REG_DROP, 32'd0);
		send_random_events(150, 16, 20000, 60);
		// hold off results so the request queue fills and stalls the input
		hold_asks++;
		quiet = 1'b1;
		send_random_events(80, 16, 5000, 50);
		quiet = 1'b0;
		drain_results();
		send_random_events(80, 16, 20000, 60);
		drain_results();

		// widest window on two sources: rings fill and wrap
		write_register(REG_WINDOW, 32'hFFFF_FFFF);
		write_register(REG_THRESHOLD, 32'd64);
		send_random_events(250, 2, 50, 85);
		drain_results();

		write_register(REG_WINDOW, 32'd0);
		write_register(REG_THRESHOLD, 32'd0);
		write_register(REG_DROP, 32'd1);
		send_random_events(150, 16, 3, 50);
		drain_results();

		write_register(REG_WINDOW, 32'd1000);
		write_register(REG_THRESHOLD, 32'd3);
		send_random_events(250, 4, 600, 70);
		drain_results();

		write_register(REG_WINDOW, 32'hFFFF_FFFF);
		write_register(REG_THRESHOLD, 32'd127);
		write_register(REG_DROP, 32'd0);
		send_random_events(150, 16, 1000, 60);
		drain_results();

		wide = {$urandom, $urandom};
		clock_now = wide[TS_BITS-1:0];
		write_register(REG_WINDOW, $urandom);
		write_register(REG_THRESHOLD, ($urandom & 32'hFFFF_FF80) | $urandom_range(0, 64));
		write_register(REG_DROP, $urandom);
		send_random_events(150, 16, $urandom_range(1, 100000), 55);
		drain_results();

		quiet = 1'b1;
		write_register(REG_WINDOW, 32'd5000);
		write_register(REG_THRESHOLD, 32'd4);
		write_register(REG_DROP, 32'd0);
		send_random_events(100, 8, 2000, 60);
		drain_results();

		if (failures == 0 && pending == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("testbench failed");
		$finish;
	end

endmodule

>>> filelist.f
hdl/pswbd_pkg.sv
hdl/pswbd_front.sv
hdl/pswbd_fifo.sv
hdl/pswbd_back.sv
hdl/per_key_sliding_window_burst_detector_unit.sv
bench/burst_checker.sv
bench/testbench.sv
